[src/psf_pkg.sv]
// Package for the prioritised substring finder: word types, register
// indexes, sizing constants and the control word between top level and cells.
// No dependencies.
`timescale 1ns / 1ps

package psf_pkg;

  localparam int PATTERN_BYTES_DEF = 8;
  localparam int MAX_STREAM_DEF    = 65535;
  localparam int NUM_PAT           = 3;
  localparam int PAT_W             = 64;
  localparam int LEN_W             = 4;
  localparam int POS_W             = 16;
  localparam int BYTE_W            = 8;
  localparam int CFG_IDX_W         = 3;
  localparam int ID_W              = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C_LEN = 3'd5;

  localparam logic [ID_W-1:0] ID_PAT_A = 2'd0;
  localparam logic [ID_W-1:0] ID_PAT_B = 2'd1;
  localparam logic [ID_W-1:0] ID_PAT_C = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   pattern_id;
    logic [POS_W-1:0]  position;
    logic              truncated;
  } out_word_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

[src/psf_cell.sv]
// One window cell: holds one byte of the sliding window and compares the
// byte it takes in against its slot of each pattern. Depends on psf_pkg.
`timescale 1ns / 1ps

module psf_cell
  import psf_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cell_ctrl_t                         ctrl,
  input  logic [BYTE_W-1:0]                  d_in,
  input  logic [NUM_PAT-1:0][PAT_W-1:0]      pat,
  input  logic [NUM_PAT-1:0][LEN_W-1:0]      len,
  output logic [BYTE_W-1:0]                  q,
  output logic [NUM_PAT-1:0]                 hit
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = '0;
    end else if (ctrl.advance) begin
      byte_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

  // Slot j of the window meets pattern byte len-1-j; past the length, pass.
  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int i = 0; i < NUM_PAT; i++) begin
      sel = len[i] - LEN_W'(IDX) - LEN_W'(1);
      if (LEN_W'(IDX) < len[i]) begin
        hit[i] = (d_in == pat[i][sel[2:0]*BYTE_W +: BYTE_W]);
      end else begin
        hit[i] = 1'b1;
      end
    end
  end

endmodule

[src/prioritized_substring_finder.sv]
// Top level of the prioritised substring finder: configuration registers,
// stream counters, first-hit tracking and the result register.
// Depends on psf_pkg and psf_cell.
//
// Usage:
//   in_valid/in_ready/in_data carry the stream, one byte per word, with
//   in_data.last on the final byte. out_valid/out_ready/out_data carry one
//   result word per stream: found, pattern_id (a before b before c), the
//   start of that pattern's first occurrence and a truncated flag.
//   cfg_we/cfg_index/cfg_wdata write the three patterns and their lengths;
//   write only while no stream is in flight.
// Timing:
//   One byte per cycle unless a result word waits on out_ready. The result
//   word appears in the cycle after the last byte is accepted. The row of
//   window cells shifts and compares all pattern slots in the cycle a byte arrives.
//   Bytes beyond MAX_STREAM are not searched and only set truncated.
// Reset and stall:
//   Reset clears the patterns, the window and all stream state. While a
//   result word waits on out_ready, in_ready drops; a new word is taken in
//   the cycle the result is taken.
`timescale 1ns / 1ps

module prioritized_substring_finder
  import psf_pkg::*;
#(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int MAX_STREAM    = MAX_STREAM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [NUM_PAT-1:0][PAT_W-1:0] pat_r;
  logic [NUM_PAT-1:0][LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_A:     pat_r[0] <= cfg_wdata;
        REG_PATTERN_A_LEN: len_r[0] <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_B:     pat_r[1] <= cfg_wdata;
        REG_PATTERN_B_LEN: len_r[1] <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_C:     pat_r[2] <= cfg_wdata;
        REG_PATTERN_C_LEN: len_r[2] <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate lengths to the window depth
  logic [NUM_PAT-1:0][LEN_W-1:0] len_sat;
  always_comb begin
    for (int i = 0; i < NUM_PAT; i++) begin
      len_sat[i] = (len_r[i] > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : len_r[i];
    end
  end

  // Stream state
  logic [POS_W-1:0]              count_r, count_nxt;
  logic [NUM_PAT-1:0]            hits_r, hits_nxt;
  logic [NUM_PAT-1:0][POS_W-1:0] first_r, first_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_word_t                     out_data_r, out_data_nxt;

  logic       accept;
  logic       searching;
  logic       done;
  logic [POS_W-1:0] count_inc;
  cell_ctrl_t ctrl;

  // Take a word whenever the result slot is free or being emptied
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign searching = accept && (count_r < POS_W'(MAX_STREAM));
  assign done      = accept && in_data.last;
  assign count_inc = count_r + POS_W'(1);

  assign ctrl.advance = searching;
  assign ctrl.clear   = done;

  // Row of window cells; cell 0 takes the incoming byte
  logic [PATTERN_BYTES-1:0][BYTE_W-1:0]  cell_q;
  logic [PATTERN_BYTES-1:0][NUM_PAT-1:0] cell_hit;

  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
    logic [BYTE_W-1:0] d_in;
    if (j == 0) begin : g_head
      assign d_in = in_data.data_byte;
    end else begin : g_link
      assign d_in = cell_q[j-1];
    end
    psf_cell #(.IDX(j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .d_in  (d_in),
      .pat   (pat_r),
      .len   (len_sat),
      .q     (cell_q[j]),
      .hit   (cell_hit[j])
    );
  end

  // Gather cell votes per pattern; a match must lie wholly inside the stream
  logic [NUM_PAT-1:0] match;
  always_comb begin
    logic all_hit;
    for (int i = 0; i < NUM_PAT; i++) begin
      all_hit = 1'b1;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
        all_hit = all_hit & cell_hit[j][i];
      end
      match[i] = searching && (len_sat[i] != '0) &&
                 (count_inc >= POS_W'(len_sat[i])) && all_hit;
    end
  end

  // Update first hits, then form the result and drop the stream state
  always_comb begin
    logic [NUM_PAT-1:0]            hits_upd;
    logic [NUM_PAT-1:0][POS_W-1:0] first_upd;
    logic                          ovf_upd;
    hits_upd  = hits_r;
    first_upd = first_r;
    ovf_upd   = ovf_r || (accept && !searching);
    for (int i = 0; i < NUM_PAT; i++) begin
      if (!hits_r[i] && match[i]) begin
        hits_upd[i]  = 1'b1;
        first_upd[i] = count_inc - POS_W'(len_sat[i]);
      end
    end

    out_data_nxt.found      = |hits_upd;
    out_data_nxt.truncated  = ovf_upd;
    if (hits_upd[0]) begin
      out_data_nxt.pattern_id = ID_PAT_A;
      out_data_nxt.position   = first_upd[0];
    end else if (hits_upd[1]) begin
      out_data_nxt.pattern_id = ID_PAT_B;
      out_data_nxt.position   = first_upd[1];
    end else if (hits_upd[2]) begin
      out_data_nxt.pattern_id = ID_PAT_C;
      out_data_nxt.position   = first_upd[2];
    end else begin
      out_data_nxt.pattern_id = ID_PAT_A;
      out_data_nxt.position   = '0;
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt = 1'b1;
    end

    if (done) begin
      count_nxt = '0;
      hits_nxt  = '0;
      first_nxt = '0;
      ovf_nxt   = 1'b0;
    end else begin
      count_nxt = searching ? count_inc : count_r;
      hits_nxt  = hits_upd;
      first_nxt = first_upd;
      ovf_nxt   = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hits_r      <= '0;
      first_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      hits_r      <= hits_nxt;
      first_r     <= first_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/psf_checker.sv]
// Port-level checks for the prioritised substring finder, bound to the top
// level. Depends on psf_pkg.
`timescale 1ns / 1ps

module psf_checker
  import psf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A result appears only after a last byte is taken
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last))
    else $error("result without a last byte");

  // Nothing found reads as a zero id and position, and the id stays in range
  a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.found ? (out_data.pattern_id != 2'd3)
                                  : (out_data.pattern_id == ID_PAT_A &&
                                     out_data.position == '0)))
    else $error("malformed result word");

  // Input stalls only while a result waits
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free result slot");

  // Reset empties the result slot
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind prioritized_substring_finder psf_checker u_psf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/testbench.sv]
// Self-checking bench for prioritized_substring_finder: streams bytes in, predicts each
// end-of-stream result in a small class and compares it with the result word.
// Depends on psf_pkg and the block under test.
`timescale 1ns / 1ps

module testbench;
  import psf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 4;     // spare cycles before a register write
  localparam int DRAIN_CYCLES   = 8;     // spare cycles at the end of the run
  localparam int RANDOM_BYTES   = 880;

  // Indexes with no register behind them: writes must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Tracks the search state of the current stream and holds the result words
  // still owed by the block, oldest first.
  class search_tracker;
    logic [PAT_W-1:0]   pat [NUM_PAT];
    logic [LEN_W-1:0]   len_reg [NUM_PAT];
    logic [ID_W-1:0]    pat_id [NUM_PAT] = '{ID_PAT_A, ID_PAT_B, ID_PAT_C};
    logic [BYTE_W-1:0]  recent [PATTERN_BYTES_DEF];
    int unsigned        seen;
    logic [NUM_PAT-1:0] hit;
    logic [POS_W-1:0]   first_pos [NUM_PAT];
    bit                 overflowed;
    out_word_t          due [$];
    int unsigned        errors;

    function new();
      foreach (pat[p]) begin
        pat[p]     = '0;
        len_reg[p] = '0;
      end
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (recent[k]) recent[k] = '0;
      foreach (first_pos[p]) first_pos[p] = '0;
      seen       = 0;
      hit        = '0;
      overflowed = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] val);
      case (idx)
        REG_PATTERN_A:     pat[0] = val;
        REG_PATTERN_A_LEN: len_reg[0] = val[LEN_W-1:0];
        REG_PATTERN_B:     pat[1] = val;
        REG_PATTERN_B_LEN: len_reg[1] = val[LEN_W-1:0];
        REG_PATTERN_C:     pat[2] = val;
        REG_PATTERN_C_LEN: len_reg[2] = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(in_word_t w);
      out_word_t res;
      int        eff;
      bit        matched;
      if (seen >= MAX_STREAM_DEF) begin
        overflowed = 1'b1;
      end else begin
        for (int k = PATTERN_BYTES_DEF - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = w.data_byte;
        seen++;
        for (int p = 0; p < NUM_PAT; p++) begin
          eff = (len_reg[p] > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : int'(len_reg[p]);
          matched = !hit[p] && eff != 0 && seen >= eff;
          for (int k = 0; k < eff; k++)
            if (recent[eff-1-k] != pat[p][BYTE_W*k +: BYTE_W]) matched = 1'b0;
          if (matched) begin
            hit[p]       = 1'b1;
            first_pos[p] = POS_W'(seen - eff);
          end
        end
      end
      if (w.last) begin
        res           = '0;
        res.truncated = overflowed;
        for (int p = NUM_PAT - 1; p >= 0; p--)
          if (hit[p]) begin
            res.found      = 1'b1;
            res.pattern_id = pat_id[p];
            res.position   = first_pos[p];
          end
        due.push_back(res);
        clear_stream();
      end
    endfunction

    function void note_error(string what);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (due.size() == 0) begin
        note_error($sformatf("unexpected word found=%0b id=%0d pos=%0d trunc=%0b",
                             got.found, got.pattern_id, got.position, got.truncated));
        return;
      end
      want = due.pop_front();
      if (got.found !== want.found || got.pattern_id !== want.pattern_id ||
          got.position !== want.position || got.truncated !== want.truncated)
        note_error($sformatf({"expected found=%0b id=%0d pos=%0d trunc=%0b, ",
                              "got found=%0b id=%0d pos=%0d trunc=%0b"},
                             want.found, want.pattern_id, want.position, want.truncated,
                             got.found, got.pattern_id, got.position, got.truncated));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_wdata;

  search_tracker tracker = new();

  bit               idling = 1'b1;    // random gaps and stalls allowed
  bit               hold_req = 1'b0;  // ask the receiver for a long hold-off
  int               bytes_sent = 0;
  int               quiet_cycles = 0;
  logic [PAT_W-1:0] cur_pat [NUM_PAT];
  logic [LEN_W-1:0] cur_len [NUM_PAT];
  logic [BYTE_W-1:0] alpha [4];       // small alphabet so that patterns recur

  prioritized_substring_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check every result word taken, and end the run if nothing has moved on
  // any port for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random short stalls while idling is on; on request, hold off
  // for a long stretch so that the result word backs up into the input.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idling && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one byte and return at the edge where it is taken. Valid stays
  // high on return; the caller either offers the next word or drops valid.
  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    in_word_t w;
    w.data_byte = b;
    w.last      = is_last;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(w);
    bytes_sent++;
  endtask

  // Send a whole stream, marking the final byte.
  task automatic send_stream(input logic [BYTE_W-1:0] s [$]);
    foreach (s[i]) offer_byte(s[i], i == s.size() - 1);
  endtask

  // Drop valid, wait until every owed result has come back, then let the
  // block finish before its registers are touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers plus one unused index. Length words carry random
  // upper bits, which the block must ignore.
  task automatic configure(input logic [PAT_W-1:0] pa, pb, pc,
                           input logic [LEN_W-1:0] la, lb, lc);
    logic [CFG_IDX_W-1:0] idx [7];
    logic [PAT_W-1:0]     val [7];
    logic [PAT_W-1:0]     noise;
    noise = {$urandom, $urandom};
    idx = '{REG_PATTERN_A, REG_PATTERN_A_LEN, REG_PATTERN_B, REG_PATTERN_B_LEN,
            REG_PATTERN_C, REG_PATTERN_C_LEN, REG_SPARE_6};
    if ($urandom_range(0, 1) == 0) idx[6] = REG_SPARE_7;
    val = '{pa, {noise[PAT_W-1:LEN_W], la}, pb, {noise[PAT_W-1:LEN_W], lb},
            pc, {noise[PAT_W-1:LEN_W], lc}, ~noise};
    foreach (idx[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_we  <= 1'b0;
    cur_pat = '{pa, pb, pc};
    cur_len = '{la, lb, lc};
  endtask

  // Random stream over the phase alphabet with stray full-range bytes, and
  // copies of the patterns planted at random places (some cut off at the end).
  task automatic random_stream();
    logic [BYTE_W-1:0] s [$];
    int n, p, at, eff;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
    repeat (n)
      s.push_back(($urandom_range(0, 7) == 0) ? BYTE_W'($urandom) : alpha[$urandom_range(0, 3)]);
    repeat ($urandom_range(0, 3)) begin
      p   = $urandom_range(0, NUM_PAT - 1);
      eff = (cur_len[p] > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : int'(cur_len[p]);
      at  = $urandom_range(0, n - 1);
      for (int k = 0; k < eff && at + k < n; k++) s[at+k] = cur_pat[p][BYTE_W*k +: BYTE_W];
    end
    send_stream(s);
  endtask

  initial begin
    logic [BYTE_W-1:0] q [$];
    logic [PAT_W-1:0]  pv [NUM_PAT];
    logic [LEN_W-1:0]  lv [NUM_PAT];
    int                phase, target, start, r;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_PATTERN_A;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Every pattern is disabled after reset: nothing found.
    q = {8'h00};
    send_stream(q);

    // Zero-length pattern of zero bytes, three zero bytes, and an all-ones
    // pattern with an over-range length that saturates to eight.
    settle();
    configure(64'h0, 64'h0, {8{8'hFF}}, 4'd0, 4'd3, 4'd15);
    q = {8'h00, 8'h00};  // the cleared window must not complete the zero pattern
    send_stream(q);
    q = {8'h00, 8'h00, 8'h00};
    send_stream(q);
    q.delete();
    repeat (PATTERN_BYTES_DEF) q.push_back(8'hFF);
    send_stream(q);

    // Priority: all three hit, then only the lowest one.
    settle();
    configure(64'h4241, 64'h41, 64'h42, 4'd2, 4'd1, 4'd1);
    q = {8'h42, 8'h41, 8'h42, 8'h41, 8'h42};
    send_stream(q);
    q = {8'h42, 8'h42};
    send_stream(q);
    q.delete();

    // Random phases, each with fresh patterns and lengths. The first uses
    // full-length patterns, the second disables all three; the third runs
    // under a long receiver hold-off with the sender never pausing.
    start = bytes_sent;
    phase = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      settle();
      idling = (bytes_sent - start < RANDOM_BYTES * 4 / 5) && ($urandom_range(0, 3) != 0);
      foreach (alpha[i]) alpha[i] = BYTE_W'($urandom);
      if (phase == 4) alpha = '{8'h00, 8'hFF, 8'h00, 8'hFF};
      for (int p = 0; p < NUM_PAT; p++) begin
        if ($urandom_range(0, 3) == 0) begin
          pv[p] = {$urandom, $urandom};
        end else begin
          for (int k = 0; k < PATTERN_BYTES_DEF; k++)
            pv[p][BYTE_W*k +: BYTE_W] = alpha[$urandom_range(0, 3)];
        end
        r = $urandom_range(0, 5);
        case (phase)
          0:       lv[p] = LEN_W'(PATTERN_BYTES_DEF);
          1:       lv[p] = '0;
          default: lv[p] = (r == 0) ? LEN_W'(0) :
                           (r == 1) ? LEN_W'($urandom_range(9, 15)) :
                                      LEN_W'($urandom_range(1, 8));
        endcase
      end
      configure(pv[0], pv[1], pv[2], lv[0], lv[1], lv[2]);
      if (phase == 2) begin
        idling   = 1'b0;
        hold_req = 1'b1;
      end
      target = bytes_sent + $urandom_range(80, 140);
      while (bytes_sent < target) random_stream();
      phase++;
    end

    // Drain and finish.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
